// ===== hdl/bbps_pkg.sv =====
// ----------------------------------------------------------------------------
// bbps_pkg: shared types and constants for the bouncing ball step block
// Fixed-point widths, register indexes, controller states, datapath commands
// and the 24-bit saturation helper.
// ----------------------------------------------------------------------------
package bbps_pkg;

  localparam int unsigned POS_W      = 24;  // positions, velocities, spin
  localparam int unsigned LIM_W      = 23;  // unsigned limits and speeds
  localparam int unsigned REST_W     = 17;  // Q1.16 restitution, below two
  localparam int unsigned DT_W       = 16;  // tick length in 2^-16 s
  localparam int unsigned ANGLE_W    = 17;  // angle in 1/256 degree
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Multiplier operands: a negated 24-bit value needs 25 bits, and the
  // unsigned 17-bit restitution needs 18 bits as a signed operand.
  localparam int unsigned MUL_A_W  = POS_W + 1;
  localparam int unsigned MUL_B_W  = REST_W + 1;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned RND_W    = PROD_W - FRAC_W;
  localparam int unsigned SUM_W    = RND_W + 1;

  // Angle reduction: a bias of ANGLE_FULL * 2^(MOD_STEPS-1) makes the sum
  // positive and below ANGLE_FULL * 2^MOD_STEPS.
  localparam int unsigned MOD_W     = 25;
  localparam int unsigned MOD_STEPS = 8;
  localparam int unsigned MOD_CNT_W = 3;
  localparam logic [MOD_W-1:0] ANGLE_FULL = 25'd92160;
  localparam logic [MOD_W-1:0] ANGLE_BIAS = ANGLE_FULL << (MOD_STEPS - 1);

  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

  localparam logic signed [POS_W-1:0] GRAVITY_RST   = -24'sd250880;
  localparam logic [REST_W-1:0]       REST_RST      = 17'd62259;
  localparam logic [LIM_W-1:0]        FLOOR_RST     = 23'd15360;
  localparam logic [LIM_W-1:0]        RADIUS_RST    = 23'd10240;
  localparam logic [LIM_W-1:0]        LEFT_RST      = 23'd10240;
  localparam logic [LIM_W-1:0]        RIGHT_RST     = 23'd153600;
  localparam logic [LIM_W-1:0]        MIN_SPEED_RST = 23'd5120;

  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GRAVITY   = 3'd0,
    CFG_REST      = 3'd1,
    CFG_FLOOR     = 3'd2,
    CFG_RADIUS    = 3'd3,
    CFG_LEFT      = 3'd4,
    CFG_RIGHT     = 3'd5,
    CFG_MIN_SPEED = 3'd6
  } cfg_addr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRAV,
    ST_VY,
    ST_PX,
    ST_PY,
    ST_CHECK,
    ST_BOUNCE_Y,
    ST_BOUNCE_X,
    ST_ROT,
    ST_MOD,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_GRAV_DT,
    MUL_VX_DT,
    MUL_VY_DT,
    MUL_VY_REST,
    MUL_VX_REST,
    MUL_SPIN_DT
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_VY_ADD,
    OP_PX_ADD,
    OP_PY_ADD,
    OP_CHECK,
    OP_VY_BOUNCE,
    OP_VX_BOUNCE,
    OP_ROT_ADD,
    OP_MOD_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t                 op;
    mul_sel_t               mul_sel;
    logic [MOD_CNT_W-1:0]   mod_shift;
    logic                   out_load;
  } dp_cmd_t;

  // Clamp a wide signed sum into the signed 24-bit range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (v[SUM_W-1:POS_W-1] == {(SUM_W-POS_W+1){v[SUM_W-1]}});
    if (fits) begin
      return v[POS_W-1:0];
    end else if (v[SUM_W-1]) begin
      return POS_MIN;
    end else begin
      return POS_MAX;
    end
  endfunction

endpackage

// ===== hdl/bouncing_ball_physics_step.sv =====
// ----------------------------------------------------------------------------
// bouncing_ball_physics_step: fixed-point bouncing ball, one step per item
// Top level: stream ports, sequencer, datapath and checks.
// ----------------------------------------------------------------------------
// A load item (tuser high) takes one result transfer: it copies the start
// fields into the ball and clears the angle. A tick goes from its input
// transfer to its result through the gravity, velocity, bounce and spin
// products of the single shared 25x18 multiplier (each product registered
// before use), the floor and wall checks, and an eight-step restoring
// reduction of the angle modulo 360 degrees. One item is in flight at a
// time; the next input transfer is taken as soon as the result sits in the
// output register, even if that result has not been taken yet.
// Configuration writes are expected only while the block is idle.
module bouncing_ball_physics_step (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [bbps_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [bbps_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // step_time[15:0], start_x[39:16], start_y[63:40], start_vel_x[87:64],
  // start_vel_y[111:88], start_spin[135:112]
  input  logic [bbps_pkg::IN_DATA_W-1:0]         in_tdata,
  // cmd: 0 tick, 1 load
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // pos_x[23:0], pos_y[47:24], vel_x[71:48], vel_y[95:72], angle[112:96],
  // zero fill[119:113]
  output logic [bbps_pkg::OUT_DATA_W-1:0]        out_tdata,
  // floor_bounce[0], wall_bounce[1]
  output logic [bbps_pkg::OUT_USER_W-1:0]        out_tuser
);
  import bbps_pkg::*;

  dp_cmd_t                 dp_cmd;
  logic signed [POS_W-1:0] pos_x, pos_y, vel_x, vel_y;
  logic [ANGLE_W-1:0]      angle;
  logic                    floor_bounce, wall_bounce;

  bbps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_load    (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .dp_cmd     (dp_cmd)
  );

  bbps_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_load          (in_tuser),
    .in_step_time     (in_tdata[15:0]),
    .in_start_x       ($signed(in_tdata[39:16])),
    .in_start_y       ($signed(in_tdata[63:40])),
    .in_start_vel_x   ($signed(in_tdata[87:64])),
    .in_start_vel_y   ($signed(in_tdata[111:88])),
    .in_start_spin    ($signed(in_tdata[135:112])),
    .out_pos_x        (pos_x),
    .out_pos_y        (pos_y),
    .out_vel_x        (vel_x),
    .out_vel_y        (vel_y),
    .out_angle        (angle),
    .out_floor_bounce (floor_bounce),
    .out_wall_bounce  (wall_bounce)
  );

  assign out_tdata = {7'b0, angle, vel_y, vel_x, pos_y, pos_x};
  assign out_tuser = {wall_bounce, floor_bounce};

`ifndef NO_ASSERTIONS
  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again right after a transfer");

  // The reduced angle always lands below one full turn.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[112:96] < ANGLE_FULL[ANGLE_W-1:0]))
    else $error("angle out of range");

  // A floor bounce places the ball on the floor, which is never negative.
  a_floor_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> !out_tdata[47])
    else $error("floor bounce with negative y");

  // A wall bounce clamps x to an unsigned limit.
  a_wall_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> !out_tdata[23])
    else $error("wall bounce with negative x");
`endif

endmodule

// ===== hdl/bbps_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbps_ctrl: sequencer for the bouncing ball step
// Walks a tick through the multiply, update, bounce and angle reduction
// steps, and owns the input ready and output valid handshakes.
// ----------------------------------------------------------------------------
module bbps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_load,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  output bbps_pkg::dp_cmd_t dp_cmd
);
  import bbps_pkg::*;

  state_t               state_r, state_nxt;
  logic [MOD_CNT_W-1:0] mod_cnt_r, mod_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mod_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    mod_cnt_nxt      = mod_cnt_r;
    dp_cmd.op        = OP_NONE;
    dp_cmd.mul_sel   = MUL_GRAV_DT;
    dp_cmd.mod_shift = mod_cnt_r;
    dp_cmd.out_load  = 1'b0;
    in_tready        = (state_r == ST_IDLE);

    // Each step that uses a product consumes the one issued in the step before it.
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          dp_cmd.op = OP_CAPTURE;
          state_nxt = in_load ? ST_DONE : ST_GRAV;
        end
      end
      ST_GRAV: begin
        dp_cmd.mul_sel = MUL_GRAV_DT;
        state_nxt      = ST_VY;
      end
      ST_VY: begin
        dp_cmd.op      = OP_VY_ADD;
        dp_cmd.mul_sel = MUL_VX_DT;
        state_nxt      = ST_PX;
      end
      ST_PX: begin
        dp_cmd.op      = OP_PX_ADD;
        dp_cmd.mul_sel = MUL_VY_DT;
        state_nxt      = ST_PY;
      end
      ST_PY: begin
        dp_cmd.op = OP_PY_ADD;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        dp_cmd.op      = OP_CHECK;
        dp_cmd.mul_sel = MUL_VY_REST;
        state_nxt      = ST_BOUNCE_Y;
      end
      ST_BOUNCE_Y: begin
        dp_cmd.op      = OP_VY_BOUNCE;
        dp_cmd.mul_sel = MUL_VX_REST;
        state_nxt      = ST_BOUNCE_X;
      end
      ST_BOUNCE_X: begin
        dp_cmd.op      = OP_VX_BOUNCE;
        dp_cmd.mul_sel = MUL_SPIN_DT;
        state_nxt      = ST_ROT;
      end
      ST_ROT: begin
        dp_cmd.op   = OP_ROT_ADD;
        mod_cnt_nxt = MOD_CNT_W'(MOD_STEPS - 1);
        state_nxt   = ST_MOD;
      end
      ST_MOD: begin
        dp_cmd.op = OP_MOD_STEP;
        if (mod_cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          mod_cnt_nxt = mod_cnt_r - 1'b1;
        end
      end
      ST_DONE: begin
        // The result register is free once its last transfer completes.
        if (!out_valid_r || out_tready) begin
          dp_cmd.out_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (dp_cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hdl/bbps_datapath.sv =====
// ----------------------------------------------------------------------------
// bbps_datapath: ball state, configuration and arithmetic
// One shared registered multiplier with round-half-up Q16 scaling, a
// saturating adder, bounce logic and a restoring angle reduction.
// ----------------------------------------------------------------------------
module bbps_datapath (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  bbps_pkg::dp_cmd_t                         cmd,
  input  logic                                      cfg_we,
  input  logic [bbps_pkg::CFG_ADDR_W-1:0]           cfg_addr,
  input  logic [bbps_pkg::CFG_DATA_W-1:0]           cfg_wdata,
  input  logic                                      in_load,
  input  logic [bbps_pkg::DT_W-1:0]                 in_step_time,
  input  logic signed [bbps_pkg::POS_W-1:0]         in_start_x,
  input  logic signed [bbps_pkg::POS_W-1:0]         in_start_y,
  input  logic signed [bbps_pkg::POS_W-1:0]         in_start_vel_x,
  input  logic signed [bbps_pkg::POS_W-1:0]         in_start_vel_y,
  input  logic signed [bbps_pkg::POS_W-1:0]         in_start_spin,
  output logic signed [bbps_pkg::POS_W-1:0]         out_pos_x,
  output logic signed [bbps_pkg::POS_W-1:0]         out_pos_y,
  output logic signed [bbps_pkg::POS_W-1:0]         out_vel_x,
  output logic signed [bbps_pkg::POS_W-1:0]         out_vel_y,
  output logic [bbps_pkg::ANGLE_W-1:0]              out_angle,
  output logic                                      out_floor_bounce,
  output logic                                      out_wall_bounce
);
  import bbps_pkg::*;

  // Configuration
  logic signed [POS_W-1:0] gravity_r;
  logic [REST_W-1:0]       rest_r;
  logic [LIM_W-1:0]        floor_r;
  logic [LIM_W-1:0]        radius_r;
  logic [LIM_W-1:0]        left_r;
  logic [LIM_W-1:0]        right_r;
  logic [LIM_W-1:0]        min_speed_r;

  // Ball state
  logic signed [POS_W-1:0] px_r, py_r, vx_r, vy_r, spin_r;
  logic [ANGLE_W-1:0]      angle_r;

  // Working registers
  logic [DT_W-1:0]         dt_r;
  logic                    floor_hit_r, wall_hit_r;
  logic signed [RND_W-1:0] prod_r;
  logic [MOD_W-1:0]        mod_r;

  // Result register
  logic signed [POS_W-1:0] res_px_r, res_py_r, res_vx_r, res_vy_r;
  logic [ANGLE_W-1:0]      res_angle_r;
  logic                    res_floor_r, res_wall_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_full, prod_rnd;
  logic signed [POS_W-1:0]   add_base;
  logic signed [SUM_W-1:0]   add_sum;
  logic signed [POS_W-1:0]   add_sat;
  logic signed [POS_W-1:0]   prod_sat;
  logic [POS_W-1:0]          prod_mag;
  logic signed [POS_W-1:0]   min_pos;
  logic signed [POS_W-1:0]   bounce_vy;
  logic [POS_W-1:0]          ground;
  logic signed [POS_W-1:0]   ground_sat;
  logic                      floor_hit, left_hit, right_hit;
  logic signed [SUM_W-1:0]   rot_sum;
  logic [MOD_W-1:0]          mod_sub, mod_nxt;

  always_comb begin
    case (cmd.mul_sel)
      MUL_GRAV_DT: begin
        mul_a = MUL_A_W'(gravity_r);
        mul_b = $signed({2'b00, dt_r});
      end
      MUL_VX_DT: begin
        mul_a = MUL_A_W'(vx_r);
        mul_b = $signed({2'b00, dt_r});
      end
      MUL_VY_DT: begin
        mul_a = MUL_A_W'(vy_r);
        mul_b = $signed({2'b00, dt_r});
      end
      MUL_VY_REST: begin
        mul_a = -MUL_A_W'(vy_r);
        mul_b = $signed({1'b0, rest_r});
      end
      MUL_VX_REST: begin
        mul_a = -MUL_A_W'(vx_r);
        mul_b = $signed({1'b0, rest_r});
      end
      MUL_SPIN_DT: begin
        mul_a = MUL_A_W'(spin_r);
        mul_b = $signed({2'b00, dt_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Adding one half and dropping the fraction rounds halves toward +infinity.
  assign prod_full = mul_a * mul_b;
  assign prod_rnd  = prod_full + $signed(PROD_W'(32768));

  always_comb begin
    case (cmd.op)
      OP_VY_ADD: add_base = vy_r;
      OP_PX_ADD: add_base = px_r;
      OP_PY_ADD: add_base = py_r;
      default:   add_base = '0;
    endcase
  end

  assign add_sum  = SUM_W'(add_base) + SUM_W'(prod_r);
  assign add_sat  = sat_pos(add_sum);
  assign prod_sat = sat_pos(SUM_W'(prod_r));

  // A bounce slower than the minimum keeps its sign; zero counts as upward.
  assign prod_mag  = prod_sat[POS_W-1] ? POS_W'(-prod_sat) : POS_W'(prod_sat);
  assign min_pos   = $signed({1'b0, min_speed_r});
  assign bounce_vy = (prod_mag < {1'b0, min_speed_r}) ?
                     (prod_sat[POS_W-1] ? -min_pos : min_pos) : prod_sat;

  assign ground     = POS_W'(floor_r) + POS_W'(radius_r);
  assign ground_sat = ground[POS_W-1] ? POS_MAX : $signed(ground);
  assign floor_hit  = (POS_W'(1)'(0) == 1'b0) &&
                      ((POS_W+1)'(py_r) < $signed({1'b0, ground}));
  assign left_hit   = (POS_W+1)'(px_r) < $signed({2'b00, left_r});
  assign right_hit  = (POS_W+1)'(px_r) > $signed({2'b00, right_r});

  assign rot_sum = $signed(SUM_W'(angle_r)) + SUM_W'(prod_r) + $signed(SUM_W'(ANGLE_BIAS));
  assign mod_sub = ANGLE_FULL << cmd.mod_shift;
  assign mod_nxt = (mod_r >= mod_sub) ? (mod_r - mod_sub) : mod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_rnd[PROD_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r   <= GRAVITY_RST;
      rest_r      <= REST_RST;
      floor_r     <= FLOOR_RST;
      radius_r    <= RADIUS_RST;
      left_r      <= LEFT_RST;
      right_r     <= RIGHT_RST;
      min_speed_r <= MIN_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_GRAVITY:   gravity_r   <= $signed(cfg_wdata);
        CFG_REST:      rest_r      <= cfg_wdata[REST_W-1:0];
        CFG_FLOOR:     floor_r     <= cfg_wdata[LIM_W-1:0];
        CFG_RADIUS:    radius_r    <= cfg_wdata[LIM_W-1:0];
        CFG_LEFT:      left_r      <= cfg_wdata[LIM_W-1:0];
        CFG_RIGHT:     right_r     <= cfg_wdata[LIM_W-1:0];
        CFG_MIN_SPEED: min_speed_r <= cfg_wdata[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r    <= '0;
      py_r    <= '0;
      vx_r    <= '0;
      vy_r    <= '0;
      spin_r  <= '0;
      angle_r <= '0;
    end else begin
      case (cmd.op)
        OP_CAPTURE: begin
          if (in_load) begin
            px_r    <= in_start_x;
            py_r    <= in_start_y;
            vx_r    <= in_start_vel_x;
            vy_r    <= in_start_vel_y;
            spin_r  <= in_start_spin;
            angle_r <= '0;
          end
        end
        OP_VY_ADD: vy_r <= add_sat;
        OP_PX_ADD: px_r <= add_sat;
        OP_PY_ADD: py_r <= add_sat;
        OP_CHECK: begin
          if (floor_hit) begin
            py_r <= ground_sat;
          end
          // The left wall wins when the limits cross.
          if (left_hit) begin
            px_r <= $signed({1'b0, left_r});
          end else if (right_hit) begin
            px_r <= $signed({1'b0, right_r});
          end
          if (left_hit || right_hit) begin
            spin_r <= sat_pos(-SUM_W'(spin_r));
          end
        end
        OP_VY_BOUNCE: begin
          if (floor_hit_r) begin
            vy_r <= bounce_vy;
          end
        end
        OP_VX_BOUNCE: begin
          if (wall_hit_r) begin
            vx_r <= prod_sat;
          end
        end
        OP_MOD_STEP: begin
          if (cmd.mod_shift == '0) begin
            angle_r <= mod_nxt[ANGLE_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        dt_r        <= in_step_time;
        floor_hit_r <= 1'b0;
        wall_hit_r  <= 1'b0;
      end
      OP_CHECK: begin
        floor_hit_r <= floor_hit;
        wall_hit_r  <= left_hit || right_hit;
      end
      OP_ROT_ADD:  mod_r <= rot_sum[MOD_W-1:0];
      OP_MOD_STEP: mod_r <= mod_nxt;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_px_r    <= px_r;
      res_py_r    <= py_r;
      res_vx_r    <= vx_r;
      res_vy_r    <= vy_r;
      res_angle_r <= angle_r;
      res_floor_r <= floor_hit_r;
      res_wall_r  <= wall_hit_r;
    end
  end

  assign out_pos_x        = res_px_r;
  assign out_pos_y        = res_py_r;
  assign out_vel_x        = res_vx_r;
  assign out_vel_y        = res_vy_r;
  assign out_angle        = res_angle_r;
  assign out_floor_bounce = res_floor_r;
  assign out_wall_bounce  = res_wall_r;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bouncing_ball_physics_step
// Load and tick items stream in under random flow control on both sides. A
// fixed-point model of the ball, kept in step with every accepted transfer
// and every register write, predicts each result, and the results are
// checked field by field in order. Register settings change between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import bbps_pkg::*;

  localparam longint SPAN_DEG  = 92160;  // 360 degrees in 1/256 degree
  localparam longint TOP24     = 8388607;
  localparam longint BOTTOM24  = -8388608;
  localparam longint TOP23     = 8388607;

  typedef struct {
    bit                      load;
    logic [DT_W-1:0]         dt;
    logic signed [POS_W-1:0] sx, sy, svx, svy, spin;
  } ball_item_t;

  typedef struct {
    logic signed [POS_W-1:0] px, py, vx, vy;
    logic [ANGLE_W-1:0]      angle;
    logic                    floor_hit, wall_hit;
  } ball_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata = '0;
  logic                    in_tuser = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic [OUT_USER_W-1:0]   out_tuser;

  ball_item_t   pending_items[$];
  ball_result_t expected_states[$];
  int           idle_pct = 23;
  int           mismatches = 0;
  logic         in_moved = 1'b0;

  // Ball state and register copies held by the predictor.
  longint ball_x, ball_y, ball_vx, ball_vy, ball_spin, ball_angle;
  longint grav_q, rest_q, floor_q, radius_q, left_q, right_q, min_speed_q;

  bouncing_ball_physics_step u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Product scaled by 2^-16, rounded to nearest with halves toward +infinity.
  function automatic longint q16_product(input longint a, input longint b);
    longint p;
    p = a * b + 32768;
    return p >>> 16;
  endfunction

  function automatic longint clamp24(input longint v);
    if (v > TOP24) return TOP24;
    if (v < BOTTOM24) return BOTTOM24;
    return v;
  endfunction

  function automatic ball_result_t ball_step(input ball_item_t it);
    ball_result_t r;
    longint dt, ground, v, mag, turn;
    r.floor_hit = 1'b0;
    r.wall_hit  = 1'b0;
    if (it.load) begin
      ball_x     = longint'(it.sx);
      ball_y     = longint'(it.sy);
      ball_vx    = longint'(it.svx);
      ball_vy    = longint'(it.svy);
      ball_spin  = longint'(it.spin);
      ball_angle = 0;
    end else begin
      dt     = longint'(it.dt);
      ground = floor_q + radius_q;
      // Vertical velocity first; y integrates the updated value.
      ball_vy = clamp24(ball_vy + q16_product(grav_q, dt));
      ball_x  = clamp24(ball_x + q16_product(ball_vx, dt));
      ball_y  = clamp24(ball_y + q16_product(ball_vy, dt));
      if (ball_y < ground) begin
        r.floor_hit = 1'b1;
        ball_y = clamp24(ground);
        v   = clamp24(q16_product(-ball_vy, rest_q));
        mag = (v < 0) ? -v : v;
        if (mag < min_speed_q) v = (v < 0) ? -min_speed_q : min_speed_q;
        ball_vy = v;
      end
      // The left wall wins even when the limits are crossed.
      if (ball_x < left_q) begin
        r.wall_hit = 1'b1;
        ball_x = left_q;
      end else if (ball_x > right_q) begin
        r.wall_hit = 1'b1;
        ball_x = right_q;
      end
      if (r.wall_hit) begin
        ball_vx   = clamp24(q16_product(-ball_vx, rest_q));
        ball_spin = clamp24(-ball_spin);
      end
      turn = ball_angle + q16_product(ball_spin, dt);
      ball_angle = ((turn % SPAN_DEG) + SPAN_DEG) % SPAN_DEG;
    end
    r.px    = ball_x[POS_W-1:0];
    r.py    = ball_y[POS_W-1:0];
    r.vx    = ball_vx[POS_W-1:0];
    r.vy    = ball_vy[POS_W-1:0];
    r.angle = ball_angle[ANGLE_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, got %0h at %0t", name, want, got, $realtime);
    end
  endtask

  // Register copies, input transfers and result transfers, all at the rising edge.
  always @(posedge clk) begin
    ball_result_t want;
    ball_item_t   it;
    if (!rst_n) begin
      ball_x = 0; ball_y = 0; ball_vx = 0; ball_vy = 0; ball_spin = 0; ball_angle = 0;
      grav_q      = longint'(GRAVITY_RST);
      rest_q      = longint'(REST_RST);
      floor_q     = longint'(FLOOR_RST);
      radius_q    = longint'(RADIUS_RST);
      left_q      = longint'(LEFT_RST);
      right_q     = longint'(RIGHT_RST);
      min_speed_q = longint'(MIN_SPEED_RST);
      in_moved <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr_t'(cfg_addr))
          CFG_GRAVITY:   grav_q      = longint'($signed(cfg_wdata));
          CFG_REST:      rest_q      = longint'(cfg_wdata[REST_W-1:0]);
          CFG_FLOOR:     floor_q     = longint'(cfg_wdata[LIM_W-1:0]);
          CFG_RADIUS:    radius_q    = longint'(cfg_wdata[LIM_W-1:0]);
          CFG_LEFT:      left_q      = longint'(cfg_wdata[LIM_W-1:0]);
          CFG_RIGHT:     right_q     = longint'(cfg_wdata[LIM_W-1:0]);
          CFG_MIN_SPEED: min_speed_q = longint'(cfg_wdata[LIM_W-1:0]);
          default: ;
        endcase
      end
      in_moved <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        it.load = in_tuser;
        {it.spin, it.svy, it.svx, it.sy, it.sx, it.dt} = in_tdata;
        expected_states.push_back(ball_step(it));
      end
      if (out_tvalid && out_tready) begin
        if (expected_states.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer %0h at %0t", out_tdata, $realtime);
        end else begin
          want = expected_states.pop_front();
          check_field("pos_x", want.px, out_tdata[23:0]);
          check_field("pos_y", want.py, out_tdata[47:24]);
          check_field("vel_x", want.vx, out_tdata[71:48]);
          check_field("vel_y", want.vy, out_tdata[95:72]);
          check_field("angle", 24'(want.angle), 24'(out_tdata[112:96]));
          check_field("floor_bounce", 24'(want.floor_hit), 24'(out_tuser[0]));
          check_field("wall_bounce", 24'(want.wall_hit), 24'(out_tuser[1]));
        end
      end
    end
  end

  // Sender: a new item goes out once the previous one has made its transfer.
  always @(negedge clk) begin
    ball_item_t it;
    if (rst_n && (!in_tvalid || in_moved)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= it.load;
        in_tdata  <= {it.spin, it.svy, it.svx, it.sy, it.sx, it.dt};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic push_load(input longint x, input longint y, input longint vx,
                           input longint vy, input longint spin, input longint dt);
    ball_item_t it;
    it.load = 1'b1;
    it.dt   = dt[DT_W-1:0];
    it.sx   = x[POS_W-1:0];
    it.sy   = y[POS_W-1:0];
    it.svx  = vx[POS_W-1:0];
    it.svy  = vy[POS_W-1:0];
    it.spin = spin[POS_W-1:0];
    pending_items.push_back(it);
  endtask

  task automatic push_tick(input longint dt);
    ball_item_t it;
    it.load = 1'b0;
    it.dt   = dt[DT_W-1:0];
    it.sx   = $urandom;
    it.sy   = $urandom;
    it.svx  = $urandom;
    it.svy  = $urandom;
    it.spin = $urandom;
    pending_items.push_back(it);
  endtask

  function automatic longint pick_dt();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 65535);
      default: return $urandom_range(400, 2200);
    endcase
  endfunction

  function automatic longint spread(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly plausible flights (a load, then a run of ticks), plus raw noise.
  task automatic fill_random(input int n);
    int ticks;
    while (pending_items.size() < n) begin
      if ($urandom_range(99) < 80) begin
        push_load($urandom_range(0, 170000), $urandom_range(15000, 200000),
                  spread(60000), spread(60000), spread(120000), $urandom);
        ticks = $urandom_range(4, 30);
        repeat (ticks) push_tick(pick_dt());
      end else if ($urandom_range(1)) begin
        push_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        push_tick($urandom);
      end
    end
  endtask

  // Every expected result is in and the block sits idle.
  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || expected_states.size() != 0)
      @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic set_config(input longint g, input longint rst, input longint fl,
                            input longint rad, input longint lft, input longint rgt,
                            input longint mspd);
    @(negedge clk); cfg_we <= 1'b1; cfg_addr <= CFG_GRAVITY;   cfg_wdata <= g[23:0];
    @(negedge clk); cfg_addr <= CFG_REST;      cfg_wdata <= rst[23:0];
    @(negedge clk); cfg_addr <= CFG_FLOOR;     cfg_wdata <= fl[23:0];
    @(negedge clk); cfg_addr <= CFG_RADIUS;    cfg_wdata <= rad[23:0];
    @(negedge clk); cfg_addr <= CFG_LEFT;      cfg_wdata <= lft[23:0];
    @(negedge clk); cfg_addr <= CFG_RIGHT;     cfg_wdata <= rgt[23:0];
    @(negedge clk); cfg_addr <= CFG_MIN_SPEED; cfg_wdata <= mspd[23:0];
    @(negedge clk); cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int idle);
    idle_pct = idle;
    fill_random(n);
    drain();
  endtask

  initial begin
    #3_200_000;
    $display("** bouncing_ball_physics_step: FAILED **");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed part under the reset settings.
    push_tick(1000);                                  // tick straight out of reset
    push_load(20480, 38400, 10240, 0, 15360, 777);    // step_time ignored on load
    push_tick(1092);
    push_tick(1092);
    push_load(40000, 0, 0, 0, 0, 0);                  // resting below the floor
    push_tick(0);                                     // zero speed bounces upward
    push_load(TOP24, TOP24, TOP24, TOP24, TOP24, 65535);
    push_tick(65535);                                 // saturation and right wall
    push_tick(65535);
    push_load(BOTTOM24, BOTTOM24, BOTTOM24, BOTTOM24, BOTTOM24, 0);
    push_tick(65535);                                 // left wall, spin flip saturates
    push_tick(32768);
    push_load(80000, 100000, -50000, 30000, -8000000, 0);
    push_tick(65535);                                 // angle wraps from below zero
    push_tick(1);
    push_load(10240, 25600, -1, 0, 1, 0);             // exactly on floor and left limit
    push_tick(1);
    push_load(153600, 200000, 300000, -200000, 92160, 0);
    push_tick(2000);
    push_tick(43690);
    push_tick(21845);
    drain();
    run_phase(200, 23);

    set_config(BOTTOM24, 0, 0, 0, 0, TOP23, 0);
    run_phase(200, 23);
    set_config(TOP24, 65536, TOP23, TOP23, TOP23, 0, TOP23);
    run_phase(150, 23);
    // Long stretch with no idling on either side.
    set_config(0, 131071, 15360, 10240, 10240, 153600, 5120);
    run_phase(250, 0);
    set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_phase(200, 23);
    set_config(-250880, 32768, 5000, 2000, 40000, 100000, 20000);
    run_phase(200, 23);
    set_config(longint'(GRAVITY_RST), longint'(REST_RST), longint'(FLOOR_RST),
               longint'(RADIUS_RST), longint'(LEFT_RST), longint'(RIGHT_RST),
               longint'(MIN_SPEED_RST));
    run_phase(350, 23);

    mismatches += expected_states.size();
    if (mismatches == 0) begin
      $display("** bouncing_ball_physics_step: PASSED **");
    end else begin
      $display("** bouncing_ball_physics_step: FAILED **");
    end
    $finish;
  end

endmodule
